// ===== hw/rtl/circle_segment_intersect_test_core_defines.svh =====
// Assertion macros for the asserting RTL file, circle_segment_intersect_test_core.sv.
`ifndef CIRCLE_SEGMENT_INTERSECT_TEST_CORE_DEFINES_SVH
`define CIRCLE_SEGMENT_INTERSECT_TEST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define CSIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csit: implication violated");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define CSIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csit: next-cycle implication violated");

`endif

// ===== hw/rtl/csit_pkg.sv =====
package csit_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = 15;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int COEF_W    = SQ_W + 2;
    localparam int F1_W      = COEF_W + 2;
    localparam int MAG_W     = COEF_W - 1;
    localparam int LO_W      = 18;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int PP_W      = 2 * LO_W;
    localparam int WIDE_W    = 72;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    // Quadratic coefficients a, b, c
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } t_coef;

    // Sign and zero facts carried to the final decision
    typedef struct packed {
        logic zero_len;
        logic c_zero;
        logic c_neg;
        logic f1_zero;
        logic f1_neg;
        logic vertex;
    } t_flags;

    // b*b and 4*a*c, with the flags that pick the answer
    typedef struct packed {
        t_flags             flags;
        logic [WIDE_W-1:0]  sq;
        logic [WIDE_W-1:0]  ac4;
    } t_disc;

endpackage

// ===== hw/rtl/csit_seg_if.sv =====
interface csit_seg_if;
    import csit_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== hw/rtl/csit_res_if.sv =====
interface csit_res_if;
    logic valid;
    logic ready;
    logic hit;
    logic zero_length;

    modport source (output valid, hit, zero_length, input ready);
    modport sink   (input valid, hit, zero_length, output ready);
endinterface

// ===== hw/rtl/csit_coef.sv =====
module csit_coef (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic signed [csit_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [csit_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [csit_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [csit_pkg::COORD_W-1:0] i_end_y,
    input  logic signed [csit_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [csit_pkg::COORD_W-1:0] i_center_y,
    input  logic        [csit_pkg::RAD_W-1:0]   i_radius,
    output logic                                o_valid,
    output csit_pkg::t_coef                     o_coef
);
    import csit_pkg::*;

    logic signed [DIFF_W-1:0] n_dx, n_dy, n_fx, n_fy;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_fx, r1_fy;
    logic        [RAD_W-1:0]  r1_rad;
    logic signed [SQ_W-1:0]   r2_dxdx, r2_dydy, r2_fxdx, r2_fydy, r2_fxfx, r2_fyfy;
    logic        [RSQ_W-1:0]  r2_rr;
    t_coef                    n_coef;
    t_coef                    r3_coef;
    logic                     r1_valid, r2_valid, r3_valid;

    // Stage 1: direction D = E - S and offset F = S - C
    always_comb begin
        n_dx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        n_dy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        n_fx = {i_start_x[COORD_W-1], i_start_x} - {i_center_x[COORD_W-1], i_center_x};
        n_fy = {i_start_y[COORD_W-1], i_start_y} - {i_center_y[COORD_W-1], i_center_y};
    end

    // Stage 3: sum the products into a, b, c
    always_comb begin
        n_coef.a = COEF_W'(r2_dxdx) + COEF_W'(r2_dydy);
        n_coef.b = (COEF_W'(r2_fxdx) + COEF_W'(r2_fydy)) <<< 1;
        n_coef.c = COEF_W'(r2_fxfx) + COEF_W'(r2_fyfy) - $signed(COEF_W'(r2_rr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_dx   <= n_dx;
            r1_dy   <= n_dy;
            r1_fx   <= n_fx;
            r1_fy   <= n_fy;
            r1_rad  <= i_radius;
            // Stage 2: one product per term
            r2_dxdx <= r1_dx * r1_dx;
            r2_dydy <= r1_dy * r1_dy;
            r2_fxdx <= r1_fx * r1_dx;
            r2_fydy <= r1_fy * r1_dy;
            r2_fxfx <= r1_fx * r1_fx;
            r2_fyfy <= r1_fy * r1_fy;
            r2_rr   <= r1_rad * r1_rad;
            r3_coef <= n_coef;
        end
    end

    assign o_valid = r3_valid;
    assign o_coef  = r3_coef;
endmodule

// ===== hw/rtl/csit_disc.sv =====
module csit_disc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  csit_pkg::t_coef i_coef,
    output logic            o_valid,
    output csit_pkg::t_disc o_disc
);
    import csit_pkg::*;

    logic signed [COEF_W-1:0] w_a, w_b, w_c;
    logic signed [COEF_W-1:0] n_negb;
    logic signed [F1_W-1:0]   n_f1, n_vsum;
    t_flags                   n_flags;
    t_flags                   r4_flags, r5_flags;
    logic [MAG_W-1:0]         r4_bm, r4_a, r4_c;
    logic [LO_W-1:0]          w_bm_hi, w_bm_lo, w_a_hi, w_a_lo, w_c_hi, w_c_lo;
    logic [PP_W-1:0]          r5_sq_hh, r5_sq_hl, r5_sq_ll;
    logic [PP_W-1:0]          r5_ac_hh, r5_ac_hl, r5_ac_lh, r5_ac_ll;
    t_disc                    n_disc;
    t_disc                    r6_disc;
    logic                     r4_valid, r5_valid, r6_valid;

    assign w_a = i_coef.a;
    assign w_b = i_coef.b;
    assign w_c = i_coef.c;

    // Stage 4: f(1), vertex window test (b < 0 and -b < 2a), magnitudes
    always_comb begin
        n_f1   = F1_W'(w_a) + F1_W'(w_b) + F1_W'(w_c);
        n_vsum = F1_W'(w_a) + F1_W'(w_a) + F1_W'(w_b);
        n_negb = -w_b;
        n_flags.zero_len = (w_a == '0);
        n_flags.c_zero   = (w_c == '0);
        n_flags.c_neg    = w_c[COEF_W-1];
        n_flags.f1_zero  = (n_f1 == '0);
        n_flags.f1_neg   = n_f1[F1_W-1];
        n_flags.vertex   = w_b[COEF_W-1] && !n_vsum[F1_W-1] && (n_vsum != '0);
    end

    // Split the 35-bit magnitudes into 18-bit halves for the partial products
    assign w_bm_hi = LO_W'(r4_bm[MAG_W-1:LO_W]);
    assign w_bm_lo = r4_bm[LO_W-1:0];
    assign w_a_hi  = LO_W'(r4_a[MAG_W-1:LO_W]);
    assign w_a_lo  = r4_a[LO_W-1:0];
    assign w_c_hi  = LO_W'(r4_c[MAG_W-1:LO_W]);
    assign w_c_lo  = r4_c[LO_W-1:0];

    // Stage 6: recombine b*b and 4*a*c
    always_comb begin
        n_disc.flags = r5_flags;
        n_disc.sq    = (WIDE_W'(r5_sq_hh) << (2 * LO_W))
                     + (WIDE_W'(r5_sq_hl) << (LO_W + 1))
                     + WIDE_W'(r5_sq_ll);
        n_disc.ac4   = ((WIDE_W'(r5_ac_hh) << (2 * LO_W))
                     + ((WIDE_W'(r5_ac_hl) + WIDE_W'(r5_ac_lh)) << LO_W)
                     + WIDE_W'(r5_ac_ll)) << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_adv) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_flags <= n_flags;
            r4_bm    <= n_negb[MAG_W-1:0];
            r4_a     <= w_a[MAG_W-1:0];
            r4_c     <= w_c[MAG_W-1:0];
            // Stage 5: partial products, 18x18 each
            r5_flags <= r4_flags;
            r5_sq_hh <= w_bm_hi * w_bm_hi;
            r5_sq_hl <= w_bm_hi * w_bm_lo;
            r5_sq_ll <= w_bm_lo * w_bm_lo;
            r5_ac_hh <= w_a_hi * w_c_hi;
            r5_ac_hl <= w_a_hi * w_c_lo;
            r5_ac_lh <= w_a_lo * w_c_hi;
            r5_ac_ll <= w_a_lo * w_c_lo;
            r6_disc  <= n_disc;
        end
    end

    assign o_valid = r6_valid;
    assign o_disc  = r6_disc;
endmodule

// ===== hw/rtl/circle_segment_intersect_test_core.sv =====
// Circle / line segment intersection test, one segment per transfer.
// Pipeline: 6 compute stages plus the output register; throughput: one
// segment per cycle while not stalled, set by the single shared pipeline
// enable that stalls only when the output is full and the sink is not ready.
// Reset (i_rst_n low at a clock edge) clears all valid bits and the circle
// registers to zero; no memory, so no clearing pass follows.
`include "circle_segment_intersect_test_core_defines.svh"

module circle_segment_intersect_test_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [csit_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csit_pkg::COORD_W-1:0]          i_cfg_data,
    csit_seg_if.sink                              i_seg,
    csit_res_if.source                            o_res
);
    import csit_pkg::*;

    // Circle registers
    logic signed [COORD_W-1:0] r_center_x, r_center_y;
    logic        [RAD_W-1:0]   r_radius;

    // Pipeline control: every stage moves together; hold all of them only
    // when the output register is full and the sink refuses the transfer.
    logic   w_adv;
    logic   w_coef_valid, w_disc_valid;
    t_coef  w_coef;
    t_disc  w_disc;
    logic   n_hit;
    logic   r_out_valid, r_hit, r_zero_length;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_seg.ready = w_adv;

    // Configuration writes must land only while the pipeline is drained; the block
    // does not enforce this. The stages read the registers directly; an unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Stages 1-3: differences, products, coefficients a, b, c
    csit_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_seg.valid),
        .i_start_x  (i_seg.start_x),
        .i_start_y  (i_seg.start_y),
        .i_end_x    (i_seg.end_x),
        .i_end_y    (i_seg.end_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_radius   (r_radius),
        .o_valid    (w_coef_valid),
        .o_coef     (w_coef)
    );

    // Stages 4-6: f(1), sign flags, exact b*b and 4*a*c
    csit_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_coef_valid),
        .i_coef  (w_coef),
        .o_valid (w_disc_valid),
        .o_disc  (w_disc)
    );

    // Stage 7: pick the answer.
    //  - degenerate segment: hit only when the point sits on the circle
    //  - an endpoint on the circle, or f(0) and f(1) of opposite sign: hit
    //  - both ends inside: miss
    //  - both ends outside: hit only if the vertex lies inside the segment
    //    and the discriminant is not negative (tangent counts)
    always_comb begin
        if (w_disc.flags.zero_len) begin
            n_hit = w_disc.flags.c_zero;
        end else if (w_disc.flags.c_zero || w_disc.flags.f1_zero) begin
            n_hit = 1'b1;
        end else if (w_disc.flags.c_neg != w_disc.flags.f1_neg) begin
            n_hit = 1'b1;
        end else if (w_disc.flags.c_neg) begin
            n_hit = 1'b0;
        end else begin
            n_hit = w_disc.flags.vertex && (w_disc.sq >= w_disc.ac4);
        end
    end

    // Output register: take a new result whenever the pipeline advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_disc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit         <= n_hit;
            r_zero_length <= w_disc.flags.zero_len;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.hit         = r_hit;
    assign o_res.zero_length = r_zero_length;

    // A zero-length segment has b == 0, so the vertex window must be closed
    `CSIT_ASSERT_IMP(a_zero_len_no_vertex, w_disc_valid && w_disc.flags.zero_len, !w_disc.flags.vertex)
    // Input is refused only while a result sits unclaimed at the output
    `CSIT_ASSERT_IMP(a_stall_only_when_full, !i_seg.ready, r_out_valid && !o_res.ready)
    // A held result keeps its value until it is taken
    `CSIT_ASSERT_NEXT(a_hold_result, r_out_valid && !o_res.ready, r_out_valid && $stable(r_hit))
endmodule
